/* sv/mmft_pkg.sv */
package mmft_pkg;

	localparam int unsigned MaxLevel = 3;
	localparam int unsigned LvlW     = 2;  // holds 0..MaxLevel
	localparam int unsigned CntW     = 3;  // face row/column, 0..2^MaxLevel-1
	localparam int unsigned CrdW     = 4;  // grid coordinate, 0..2^MaxLevel
	localparam int unsigned IdxW     = 32;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} mmft_state_t;

	// sequencer view handed to the vertex units
	typedef struct packed {
		logic            run;
		logic [CntW-1:0] fx;
		logic [CntW-1:0] fy;
		logic [LvlW-1:0] level;
		logic [2:0]      collapse;  // edge level below the face level, per edge
		logic            last;
	} mmft_ctrl_t;

	// vertices in a base triangle of the given level: (n+1)(n+2)/2
	function automatic logic [IdxW-1:0] vert_count(input logic [LvlW-1:0] lvl);
		logic [CrdW:0]   n1;
		logic [2*CrdW+1:0] prod;
		begin
			n1   = (CrdW+1)'((CrdW+1)'(1) << lvl) + (CrdW+1)'(1);
			prod = (2*CrdW+2)'(n1) * (2*CrdW+2)'(n1 + (CrdW+1)'(1));
			vert_count = IdxW'(prod >> 1);
		end
	endfunction

	// triangular number y(y+1)/2 for a grid row
	function automatic logic [2*CrdW-1:0] tri_num(input logic [CrdW-1:0] y);
		logic [2*CrdW-1:0] prod;
		begin
			prod    = (2*CrdW)'(y) * (2*CrdW)'(y + CrdW'(1));
			tri_num = prod >> 1;
		end
	endfunction

endpackage

/* sv/mmft_vertex.sv */
module mmft_vertex
	import mmft_pkg::*;
(
	input  logic [CrdW-1:0] x,
	input  logic [CrdW-1:0] y,
	input  logic            flip,
	input  logic [LvlW-1:0] level,
	input  logic [2:0]      collapse,
	input  logic [IdxW-1:0] base,
	output logic [IdxW-1:0] index,
	output logic [CrdW-1:0] grid_x,
	output logic [CrdW-1:0] grid_y
);

	logic [CrdW-1:0] n;
	logic [CrdW-1:0] half;
	logic [CrdW-1:0] vx;
	logic [CrdW-1:0] vy;

	assign n    = CrdW'(CrdW'(1) << level);
	assign half = n >> 1;
	assign vx   = flip ? n - x : x;
	assign vy   = flip ? n - y : y;

	assign index = base + IdxW'(tri_num(vy)) + IdxW'(vx);

	// odd vertices on a coarser edge snap to an even neighbour
	always_comb begin
		grid_x = vx;
		grid_y = vy;
		if (collapse[0] && vx == '0 && vy[0]) begin
			grid_y = (vy < half) ? vy - CrdW'(1) : vy + CrdW'(1);
		end else if (collapse[1] && vy == n && vx[0]) begin
			grid_x = (vx < half) ? vx - CrdW'(1) : vx + CrdW'(1);
		end else if (collapse[2] && vx == vy && vx[0]) begin
			grid_x = (vx < half) ? vx + CrdW'(1) : vx - CrdW'(1);
			grid_y = grid_x;
		end
	end

endmodule

/* sv/mmft_seq.sv */
module mmft_seq
	import mmft_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [LvlW-1:0] lvl0,
	input  logic [LvlW-1:0] lvl1,
	input  logic [LvlW-1:0] lvl2,
	input  logic            adv,
	output logic            in_ready,
	output mmft_ctrl_t      ctrl,
	output logic [IdxW-1:0] base
);

	mmft_state_t     state_q, state_d;
	logic [CntW-1:0] fx_q, fy_q;
	logic [LvlW-1:0] level_q;
	logic [2:0]      coll_q;
	logic [IdxW-1:0] base_q;
	logic [CntW-1:0] nm1;
	logic            last;
	logic            accept;
	logic            step;
	logic            run;
	logic [LvlW-1:0] lmax;

	assign lmax   = (lvl0 > lvl1) ? ((lvl0 > lvl2) ? lvl0 : lvl2)
	                              : ((lvl1 > lvl2) ? lvl1 : lvl2);
	assign nm1    = CntW'((CrdW'(1) << level_q) - CrdW'(1));
	assign last   = (fx_q == nm1) && (fy_q == nm1);
	assign accept = in_valid && in_ready;
	assign step   = run && adv;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid)    state_d = ST_RUN;
			ST_RUN:  if (adv && last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		run      = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_RUN:  run      = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	assign ctrl.run      = run;
	assign ctrl.fx       = fx_q;
	assign ctrl.fy       = fy_q;
	assign ctrl.level    = level_q;
	assign ctrl.collapse = coll_q;
	assign ctrl.last     = last;
	assign base          = base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fx_q    <= '0;
			fy_q    <= '0;
			level_q <= '0;
			coll_q  <= '0;
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fx_q    <= '0;
				fy_q    <= '0;
				level_q <= lmax;
				coll_q  <= {lvl2 < lmax, lvl1 < lmax, lvl0 < lmax};
			end else if (step) begin
				if (fx_q == nm1) begin
					fx_q <= '0;
					fy_q <= fy_q + CntW'(1);
				end else begin
					fx_q <= fx_q + CntW'(1);
				end
				if (last) base_q <= base_q + vert_count(level_q);
			end
		end
	end

	a_start_origin: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (fx_q == '0 && fy_q == '0 && state_q == ST_RUN))
		else $error("walk did not start at face origin");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last) |=> (state_q == ST_IDLE))
		else $error("sequencer kept running past final microtriangle");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		run |-> (fx_q <= nm1 && fy_q <= nm1))
		else $error("face counter out of range");

	a_base_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && last) |=> $stable(base_q))
		else $error("vertex base moved mid-face");

endmodule

/* sv/micromesh_face_tessellator.sv */
// Path: the input beat loads the sequencer registers; each microtriangle is then computed
//   combinationally from them and registered in the output register before it leaves.
// Throughput: one microtriangle per cycle while the output does not stall; a base triangle
//   of level L (n = 2^L) yields n*n of them, and the input side opens again only when idle.
// Output stalls freeze the face walk; a new input beat may land while the final one waits.
// Reset (arst_n low, async): sequencer idle, output empty, vertex base cleared to zero.
module micromesh_face_tessellator
	import mmft_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // level_edge_zero, level_edge_one, level_edge_two, pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // index_first, index_second, index_third,
	                                // first_grid_x, first_grid_y, second_grid_x,
	                                // second_grid_y, third_grid_x, third_grid_y
	output logic         m_tlast    // last_of_face
);

	mmft_ctrl_t      ctrl;
	logic [IdxW-1:0] base;
	logic            adv;
	logic            flip;

	logic [CrdW-1:0] ax, ay, bx, by, cx, cy;
	logic [IdxW-1:0] idx_a, idx_b, idx_c;
	logic [CrdW-1:0] gax, gay, gbx, gby, gcx, gcy;

	logic            m_valid_q;
	logic [119:0]    m_data_q;
	logic            m_last_q;

	// output register free or draining this cycle
	assign adv = !m_valid_q || m_tready;

	mmft_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.lvl0     (s_tdata[1:0]),
		.lvl1     (s_tdata[3:2]),
		.lvl2     (s_tdata[5:4]),
		.adv      (adv),
		.in_ready (s_tready),
		.ctrl     (ctrl),
		.base     (base)
	);

	// microtriangle (fx,fy): (fx,fy), (fx,fy+1), (fx+1,fy+1); upper ones mirrored about (n/2,n/2)
	assign flip = ctrl.fx > ctrl.fy;
	assign ax   = CrdW'(ctrl.fx);
	assign ay   = CrdW'(ctrl.fy);
	assign bx   = ax;
	assign by   = ay + CrdW'(1);
	assign cx   = ax + CrdW'(1);
	assign cy   = by;

	mmft_vertex u_va (
		.x(ax), .y(ay), .flip(flip), .level(ctrl.level), .collapse(ctrl.collapse),
		.base(base), .index(idx_a), .grid_x(gax), .grid_y(gay)
	);

	mmft_vertex u_vb (
		.x(bx), .y(by), .flip(flip), .level(ctrl.level), .collapse(ctrl.collapse),
		.base(base), .index(idx_b), .grid_x(gbx), .grid_y(gby)
	);

	mmft_vertex u_vc (
		.x(cx), .y(cy), .flip(flip), .level(ctrl.level), .collapse(ctrl.collapse),
		.base(base), .index(idx_c), .grid_x(gcx), .grid_y(gcy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= ctrl.run;
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (adv && ctrl.run) begin
			m_data_q <= {gcy, gcx, gby, gbx, gay, gax, idx_c, idx_b, idx_a};
			m_last_q <= ctrl.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule
